// ===== hw/rtl/lpp_pkg.sv =====
// ----------------------------------------------------------------------------
// Lattice predator-prey package
// Shared types, codes and reset constants for the lattice update engine.
// ----------------------------------------------------------------------------
`default_nettype none

package lpp_pkg;

    // Default lattice side length.
    localparam int SIDE_DEFAULT = 512;

    // Fixed widths of the item fields.
    localparam int POS_W   = 9;
    localparam int TOTAL_W = 19;
    localparam int DRAW_W  = 64;
    localparam int OCC_W   = 2;
    localparam int MODE_W  = 3;
    localparam int DIR_W   = 2;
    localparam int CFG_IDX_W = 3;

    // Event modes.
    localparam logic [MODE_W-1:0] MODE_DIE   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_EAT   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_BIRTH = 3'd2;
    localparam logic [MODE_W-1:0] MODE_IDLE  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_INIT  = 3'd4;

    // Neighbor directions.
    localparam logic [DIR_W-1:0] DIR_ROW_INC = 2'd0;
    localparam logic [DIR_W-1:0] DIR_ROW_DEC = 2'd1;
    localparam logic [DIR_W-1:0] DIR_COL_INC = 2'd2;
    localparam logic [DIR_W-1:0] DIR_COL_DEC = 2'd3;

    // Cell occupants.
    localparam logic [OCC_W-1:0] OCC_EMPTY = 2'd0;
    localparam logic [OCC_W-1:0] OCC_PREY  = 2'd1;
    localparam logic [OCC_W-1:0] OCC_PRED  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DEATH      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EAT        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIRTH      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_PRED  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_PREY  = 3'd4;

    // Configuration reset values (unsigned 0.64 fractions).
    localparam logic [DRAW_W-1:0] DEATH_RESET     = 64'd461168601842738790;
    localparam logic [DRAW_W-1:0] EAT_RESET       = 64'd4611686018427387904;
    localparam logic [DRAW_W-1:0] BIRTH_RESET     = 64'd18446744073709551615;
    localparam logic [DRAW_W-1:0] INIT_PRED_RESET = 64'd5534023222112865484;
    localparam logic [DRAW_W-1:0] INIT_PREY_RESET = 64'd11068046444225730969;

    typedef struct packed {
        logic [DRAW_W-1:0] death_threshold;
        logic [DRAW_W-1:0] eat_threshold;
        logic [DRAW_W-1:0] birth_threshold;
        logic [DRAW_W-1:0] init_predator_bound;
        logic [DRAW_W-1:0] init_prey_bound;
    } lpp_cfg_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
        logic [DIR_W-1:0]  direction;
        logic [DRAW_W-1:0] draw;
    } lpp_item_t;

    typedef struct packed {
        logic               changed;
        logic [POS_W-1:0]   target_x;
        logic [POS_W-1:0]   target_y;
        logic [OCC_W-1:0]   new_occupant;
        logic [TOTAL_W-1:0] predator_total;
        logic [TOTAL_W-1:0] prey_total;
    } lpp_result_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EVAL
    } lpp_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lpp_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module lpp_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr_a,
    output logic      [WIDTH-1:0] rdata_a,
    input  wire logic [AW-1:0]    raddr_b,
    output logic      [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/lpp_cfg.sv =====
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the event probability thresholds and the initialization bounds.
// ----------------------------------------------------------------------------
`default_nettype none

module lpp_cfg
    import lpp_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DRAW_W-1:0]    cfg_data,
    output lpp_cfg_t                  cfg
);

    logic [DRAW_W-1:0] death_reg;
    logic [DRAW_W-1:0] eat_reg;
    logic [DRAW_W-1:0] birth_reg;
    logic [DRAW_W-1:0] init_pred_reg;
    logic [DRAW_W-1:0] init_prey_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            death_reg     <= DEATH_RESET;
            eat_reg       <= EAT_RESET;
            birth_reg     <= BIRTH_RESET;
            init_pred_reg <= INIT_PRED_RESET;
            init_prey_reg <= INIT_PREY_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DEATH:     death_reg     <= cfg_data;
                CFG_EAT:       eat_reg       <= cfg_data;
                CFG_BIRTH:     birth_reg     <= cfg_data;
                CFG_INIT_PRED: init_pred_reg <= cfg_data;
                CFG_INIT_PREY: init_prey_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    assign cfg.death_threshold     = death_reg;
    assign cfg.eat_threshold       = eat_reg;
    assign cfg.birth_threshold     = birth_reg;
    assign cfg.init_predator_bound = init_pred_reg;
    assign cfg.init_prey_bound     = init_prey_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/lattice_predator_prey_update.sv =====
// ----------------------------------------------------------------------------
// Lattice predator-prey update engine
// Applies one Monte Carlo event per transfer to a wrap-around lattice.
// ----------------------------------------------------------------------------
// The lattice of SIDE by SIDE cells lives in a dual-read-port RAM, and the
// predator and prey totals live in registers. After reset the engine first
// sweeps the RAM to empty, one cell per cycle; no item transfer is taken
// during that sweep, though configuration writes are. After that each event
// passes through a read state and then an evaluate state. In the read state
// the chosen cell and its neighbor are read together from the RAM and the
// threshold compare is registered; in the evaluate state the event is
// decided, at most one cell is written back, the totals are updated and the
// result is loaded into the output register. The next item is taken in the
// evaluate state, so the engine cannot take a new event before the last one
// is through. Since the write lands before the following event reads, no
// forwarding is needed. A result that is held by result_stall keeps the
// engine in its evaluate state until the output register frees up.
// Coordinates beyond the lattice are folded back modulo SIDE, and target
// coordinates and totals are cut to their field widths.
// ----------------------------------------------------------------------------
`default_nettype none

module lattice_predator_prey_update
    import lpp_pkg::*;
#(
    parameter int SIDE = SIDE_DEFAULT
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 item_valid,
    output logic                      item_stall,
    input  wire lpp_item_t            item,
    output logic                      result_valid,
    input  wire logic                 result_stall,
    output lpp_result_t               result,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DRAW_W-1:0]    cfg_data
);

    localparam int DEPTH   = SIDE * SIDE;
    localparam int AW      = $clog2(DEPTH);
    localparam int CW      = $clog2(SIDE);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int POS_MAX = (1 << POS_W) - 1;

    // Folds a coordinate field into the lattice by compare and subtract of
    // shifted copies of SIDE, largest first.
    function automatic logic [CW-1:0] wrap_coord(input logic [POS_W-1:0] v);
        logic [POS_W+1:0] r;
        r = {2'b00, v};
        for (int k = POS_W - 1; k >= 0; k--)
        begin
            if ((SIDE << k) <= POS_MAX)
            begin
                if (r >= (POS_W+2)'(SIDE << k))
                begin
                    r = r - (POS_W+2)'(SIDE << k);
                end
            end
        end
        return CW'(r);
    endfunction

    lpp_cfg_t cfg;

    lpp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Control registers.
    lpp_state_t         state_reg, state_next;
    logic [AW-1:0]      clr_reg, clr_next;
    logic [CNT_W-1:0]   pred_reg, pred_next;
    logic [CNT_W-1:0]   prey_reg, prey_next;
    logic               out_valid_reg, out_valid_next;

    // Event payload registers.
    logic [MODE_W-1:0]  mode_reg;
    logic [CW-1:0]      x_reg, y_reg, nx_reg, ny_reg;
    logic [DRAW_W-1:0]  draw_reg;
    logic               pass_reg, pass_next;
    logic [OCC_W-1:0]   init_occ_reg, init_occ_next;
    lpp_result_t        out_reg, out_next;

    // Accept-side coordinate logic.
    logic [CW-1:0]      x_in, y_in, nx_in, ny_in;

    // RAM ports.
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [OCC_W-1:0]   ram_wdata;
    logic [AW-1:0]      addr_here, addr_there;
    logic [OCC_W-1:0]   here, there;

    // Event decision.
    logic               wrote;
    logic               use_nb;
    logic [OCC_W-1:0]   occ;
    logic [OCC_W-1:0]   old_occ;
    logic               slot_free;
    logic               take_item;
    logic               commit;
    logic [DRAW_W-1:0]  thr_sel;

    // The output register can be loaded when it is empty or being drained.
    assign slot_free = !out_valid_reg || !result_stall;

    assign item_stall = !((state_reg == ST_IDLE) ||
                          ((state_reg == ST_EVAL) && slot_free));

    // Fold the coordinates and find the neighbor with wrap-around.
    always_comb
    begin
        x_in  = wrap_coord(item.pos_x);
        y_in  = wrap_coord(item.pos_y);
        nx_in = x_in;
        ny_in = y_in;
        case (item.direction)
            DIR_ROW_INC: ny_in = (y_in == CW'(SIDE - 1)) ? '0 : CW'(y_in + 1'b1);
            DIR_ROW_DEC: ny_in = (y_in == '0) ? CW'(SIDE - 1) : CW'(y_in - 1'b1);
            DIR_COL_INC: nx_in = (x_in == CW'(SIDE - 1)) ? '0 : CW'(x_in + 1'b1);
            DIR_COL_DEC: nx_in = (x_in == '0) ? CW'(SIDE - 1) : CW'(x_in - 1'b1);
            default:     nx_in = x_in;
        endcase
    end

    assign addr_here  = AW'(AW'(y_reg) * AW'(SIDE) + AW'(x_reg));
    assign addr_there = AW'(AW'(ny_reg) * AW'(SIDE) + AW'(nx_reg));

    lpp_ram #(
        .WIDTH (OCC_W),
        .DEPTH (DEPTH)
    ) u_cells (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (addr_here),
        .rdata_a (here),
        .raddr_b (addr_there),
        .rdata_b (there)
    );

    // Threshold compares, registered at the end of the read cycle. A
    // threshold of all ones always passes.
    always_comb
    begin
        case (mode_reg)
            MODE_DIE: thr_sel = cfg.death_threshold;
            MODE_EAT: thr_sel = cfg.eat_threshold;
            default:  thr_sel = cfg.birth_threshold;
        endcase
        pass_next = (thr_sel == '1) || (draw_reg < thr_sel);

        if (draw_reg < cfg.init_predator_bound)
        begin
            init_occ_next = OCC_PRED;
        end
        else if (draw_reg < cfg.init_prey_bound)
        begin
            init_occ_next = OCC_PREY;
        end
        else
        begin
            init_occ_next = OCC_EMPTY;
        end
    end

    // Decide the event from the two cells just read.
    always_comb
    begin
        wrote   = 1'b0;
        use_nb  = 1'b0;
        occ     = OCC_EMPTY;
        old_occ = here;
        case (mode_reg)
            MODE_DIE:
            begin
                wrote = (here == OCC_PRED) && pass_reg;
            end
            MODE_EAT:
            begin
                wrote   = (here == OCC_PRED) && (there == OCC_PREY) && pass_reg;
                use_nb  = 1'b1;
                occ     = OCC_PRED;
                old_occ = there;
            end
            MODE_BIRTH:
            begin
                wrote   = (here == OCC_PREY) && (there == OCC_EMPTY) && pass_reg;
                use_nb  = 1'b1;
                occ     = OCC_PREY;
                old_occ = there;
            end
            MODE_INIT:
            begin
                wrote = 1'b1;
                occ   = init_occ_reg;
            end
            default:
            begin
                wrote = 1'b0;
            end
        endcase
    end

    // Sequencer: clearing sweep, then read and evaluate for each event.
    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        ram_we     = 1'b0;
        ram_waddr  = addr_here;
        ram_wdata  = OCC_EMPTY;
        take_item  = 1'b0;
        commit     = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                clr_next  = AW'(clr_reg + 1'b1);
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    take_item  = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (slot_free)
                begin
                    commit    = 1'b1;
                    ram_we    = wrote;
                    ram_waddr = use_nb ? addr_there : addr_here;
                    ram_wdata = occ;
                    if (item_valid)
                    begin
                        take_item  = 1'b1;
                        state_next = ST_READ;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Totals follow the cell that is overwritten and the new occupant.
    always_comb
    begin
        pred_next = pred_reg;
        prey_next = prey_reg;
        if (commit && wrote)
        begin
            if (old_occ == OCC_PRED)
            begin
                pred_next = CNT_W'(pred_next - 1'b1);
            end
            if (old_occ == OCC_PREY)
            begin
                prey_next = CNT_W'(prey_next - 1'b1);
            end
            if (occ == OCC_PRED)
            begin
                pred_next = CNT_W'(pred_next + 1'b1);
            end
            if (occ == OCC_PREY)
            begin
                prey_next = CNT_W'(prey_next + 1'b1);
            end
        end
    end

    // Result item; an event without a write reports zero target fields.
    always_comb
    begin
        out_next.changed        = wrote;
        out_next.target_x       = '0;
        out_next.target_y       = '0;
        out_next.new_occupant   = OCC_EMPTY;
        out_next.predator_total = TOTAL_W'(pred_next);
        out_next.prey_total     = TOTAL_W'(prey_next);
        if (wrote)
        begin
            out_next.target_x     = POS_W'(use_nb ? nx_reg : x_reg);
            out_next.target_y     = POS_W'(use_nb ? ny_reg : y_reg);
            out_next.new_occupant = occ;
        end

        out_valid_next = out_valid_reg;
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            pred_reg      <= '0;
            prey_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            pred_reg      <= pred_next;
            prey_reg      <= prey_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_item)
        begin
            mode_reg <= item.mode;
            x_reg    <= x_in;
            y_reg    <= y_in;
            nx_reg   <= nx_in;
            ny_reg   <= ny_in;
            draw_reg <= item.draw;
        end
        if (state_reg == ST_READ)
        begin
            pass_reg     <= pass_next;
            init_occ_reg <= init_occ_next;
        end
        if (commit)
        begin
            out_reg <= out_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

`default_nettype wire

// ===== dv/lattice_predator_prey_update_tb.sv =====
// ----------------------------------------------------------------------------
// Lattice predator-prey update engine testbench
// Drives Monte Carlo events into the engine and checks every result against
// an in-bench lattice predictor, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module lattice_predator_prey_update_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lpp_pkg::*;

    localparam int SIDE = SIDE_DEFAULT;
    localparam int CELLS = SIDE * SIDE;
    localparam logic [DRAW_W-1:0] ALL_ONES = '1;
    localparam logic [DRAW_W-1:0] HALF = 64'h8000_0000_0000_0000;
    // Random events are packed into a small square of cells so that predators
    // and prey actually meet; on a mostly empty lattice almost nothing fires.
    localparam int WINDOW = 6;
    // Settling wait after the last result before touching the registers.
    localparam int SETTLE_CYCLES = 8;
    // Allows for the clearing sweep as well as the traffic after it.
    localparam int WATCHDOG_NS = 4_000_000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 item_valid = 1'b0;
    logic                 item_stall;
    lpp_item_t            item = '0;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    lpp_result_t          result;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_DEATH;
    logic [DRAW_W-1:0]    cfg_data = '0;

    // Predictor state: our own copy of the lattice, the totals and the
    // threshold registers.
    logic [OCC_W-1:0] lattice_cells [CELLS];
    int unsigned      predator_cells;
    int unsigned      prey_cells;
    lpp_cfg_t         thresholds;

    // Results that the lattice predictor has worked out, oldest first.
    lpp_result_t pending_results [$];

    int          error_count = 0;
    bit          sender_gaps_on = 1'b1;
    bit          receiver_gaps_on = 1'b1;
    // Set by a test to make the receiver hold off for that many cycles.
    int unsigned receiver_hold_cycles = 0;
    int unsigned window_x = 0;
    int unsigned window_y = 0;

    lattice_predator_prey_update dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Idle stretch length: mostly none or short, now and then long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // A probability test passes below the threshold, and always when the
    // threshold is all ones.
    function automatic bit draw_passes(input logic [DRAW_W-1:0] draw,
                                       input logic [DRAW_W-1:0] limit);
        return (limit == ALL_ONES) || (draw < limit);
    endfunction

    function automatic lpp_item_t make_event(input logic [MODE_W-1:0] mode,
                                             input int unsigned x,
                                             input int unsigned y,
                                             input logic [DIR_W-1:0] direction,
                                             input logic [DRAW_W-1:0] draw);
        lpp_item_t ev;
        ev.mode = mode;
        ev.pos_x = POS_W'(x);
        ev.pos_y = POS_W'(y);
        ev.direction = direction;
        ev.draw = draw;
        return ev;
    endfunction

    // One random event. Well-formed events land inside the current window and
    // often use draws that sit on or next to the threshold that matters; noise
    // events take any value of any field, unused modes included.
    function automatic lpp_item_t random_event(input bit noisy);
        lpp_item_t        ev;
        int unsigned      r;
        logic [DRAW_W-1:0] hint;
        if (noisy)
        begin
            ev.mode = MODE_W'($urandom_range(0, 7));
            ev.pos_x = POS_W'($urandom);
            ev.pos_y = POS_W'($urandom);
            ev.direction = DIR_W'($urandom);
            ev.draw = {$urandom, $urandom};
            return ev;
        end
        r = $urandom_range(0, 99);
        if (r < 15)
            ev.mode = MODE_INIT;
        else if (r < 35)
            ev.mode = MODE_DIE;
        else if (r < 65)
            ev.mode = MODE_EAT;
        else if (r < 95)
            ev.mode = MODE_BIRTH;
        else
            ev.mode = MODE_IDLE;
        ev.pos_x = POS_W'((window_x + $urandom_range(0, WINDOW - 1)) % SIDE);
        ev.pos_y = POS_W'((window_y + $urandom_range(0, WINDOW - 1)) % SIDE);
        ev.direction = DIR_W'($urandom);
        case (ev.mode)
            MODE_DIE:   hint = thresholds.death_threshold;
            MODE_EAT:   hint = thresholds.eat_threshold;
            MODE_BIRTH: hint = thresholds.birth_threshold;
            default:    hint = $urandom_range(0, 1) ? thresholds.init_predator_bound
                                                    : thresholds.init_prey_bound;
        endcase
        r = $urandom_range(0, 9);
        case (r)
            0:       ev.draw = '0;
            1:       ev.draw = ALL_ONES;
            2:       ev.draw = hint - 1;
            3:       ev.draw = hint;
            4:       ev.draw = hint + 1;
            default: ev.draw = {$urandom, $urandom};
        endcase
        return ev;
    endfunction

    // Threshold for a random register setting, with the extremes and their
    // neighbors weighted in.
    function automatic logic [DRAW_W-1:0] random_threshold();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return ALL_ONES;
            2:       return ALL_ONES - 1;
            3:       return 64'd1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Lattice predictor: applies one accepted event to the lattice copy and
    // queues the result the engine must give for it.
    task automatic predict_event(input lpp_item_t ev);
        int unsigned       x;
        int unsigned       y;
        int unsigned       nx;
        int unsigned       ny;
        int unsigned       tx;
        int unsigned       ty;
        logic [OCC_W-1:0]  here;
        logic [OCC_W-1:0]  there;
        logic [OCC_W-1:0]  occ;
        logic [OCC_W-1:0]  old;
        bit                wrote;
        lpp_result_t       expected;
        x = ev.pos_x % SIDE;
        y = ev.pos_y % SIDE;
        nx = x;
        ny = y;
        // The neighbor wraps around the lattice edges.
        case (ev.direction)
            DIR_ROW_INC: ny = (y + 1 == SIDE) ? 0 : y + 1;
            DIR_ROW_DEC: ny = (y == 0) ? SIDE - 1 : y - 1;
            DIR_COL_INC: nx = (x + 1 == SIDE) ? 0 : x + 1;
            default:     nx = (x == 0) ? SIDE - 1 : x - 1;
        endcase
        here = lattice_cells[y * SIDE + x];
        there = lattice_cells[ny * SIDE + nx];
        wrote = 1'b0;
        tx = 0;
        ty = 0;
        occ = OCC_EMPTY;
        case (ev.mode)
            MODE_DIE:
                if (here == OCC_PRED && draw_passes(ev.draw, thresholds.death_threshold))
                begin
                    wrote = 1'b1;
                    tx = x;
                    ty = y;
                    occ = OCC_EMPTY;
                end
            MODE_EAT:
                if (here == OCC_PRED && there == OCC_PREY
                    && draw_passes(ev.draw, thresholds.eat_threshold))
                begin
                    wrote = 1'b1;
                    tx = nx;
                    ty = ny;
                    occ = OCC_PRED;
                end
            MODE_BIRTH:
                if (here == OCC_PREY && there == OCC_EMPTY
                    && draw_passes(ev.draw, thresholds.birth_threshold))
                begin
                    wrote = 1'b1;
                    tx = nx;
                    ty = ny;
                    occ = OCC_PREY;
                end
            MODE_INIT:
            begin
                // Initialization is a plain compare; all ones is no special
                // value here, and the cell counts as written even if unchanged.
                wrote = 1'b1;
                tx = x;
                ty = y;
                if (ev.draw < thresholds.init_predator_bound)
                    occ = OCC_PRED;
                else if (ev.draw < thresholds.init_prey_bound)
                    occ = OCC_PREY;
                else
                    occ = OCC_EMPTY;
            end
            default:
                ;
        endcase
        if (wrote)
        begin
            old = lattice_cells[ty * SIDE + tx];
            if (old == OCC_PRED && predator_cells > 0)
                predator_cells--;
            if (old == OCC_PREY && prey_cells > 0)
                prey_cells--;
            lattice_cells[ty * SIDE + tx] = occ;
            if (occ == OCC_PRED)
                predator_cells++;
            if (occ == OCC_PREY)
                prey_cells++;
        end
        expected.changed = wrote;
        expected.target_x = POS_W'(tx);
        expected.target_y = POS_W'(ty);
        expected.new_occupant = occ;
        expected.predator_total = TOTAL_W'(predator_cells);
        expected.prey_total = TOTAL_W'(prey_cells);
        pending_results.push_back(expected);
    endtask

    // Offers one event after an optional gap and holds it until the transfer.
    // The predictor runs at the edge where the engine takes it.
    task automatic send_event(input lpp_item_t ev);
        int unsigned gap;
        gap = sender_gaps_on ? pick_gap() : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item <= ev;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        predict_event(ev);
    endtask

    // Stops offering items and waits until every predicted result is back.
    task automatic drain_results();
        @(negedge clk);
        item_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [DRAW_W-1:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        case (index)
            CFG_DEATH:     thresholds.death_threshold = value;
            CFG_EAT:       thresholds.eat_threshold = value;
            CFG_BIRTH:     thresholds.birth_threshold = value;
            CFG_INIT_PRED: thresholds.init_predator_bound = value;
            CFG_INIT_PREY: thresholds.init_prey_bound = value;
            default:       ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic write_all_registers(input logic [DRAW_W-1:0] death,
                                       input logic [DRAW_W-1:0] eat,
                                       input logic [DRAW_W-1:0] birth,
                                       input logic [DRAW_W-1:0] init_pred,
                                       input logic [DRAW_W-1:0] init_prey);
        write_register(CFG_DEATH, death);
        write_register(CFG_EAT, eat);
        write_register(CFG_BIRTH, birth);
        write_register(CFG_INIT_PRED, init_pred);
        write_register(CFG_INIT_PREY, init_prey);
    endtask

    // Moves the event window, sometimes across the lattice edge so that the
    // neighbor wrap is hit, seeds it with initialization events and then runs
    // a mix of well-formed events and noise.
    task automatic run_event_burst(input int unsigned count);
        window_x = ($urandom_range(0, 2) == 0) ? SIDE - WINDOW / 2 : $urandom_range(0, SIDE - 1);
        window_y = ($urandom_range(0, 2) == 0) ? SIDE - WINDOW / 2 : $urandom_range(0, SIDE - 1);
        for (int i = 0; i < WINDOW * WINDOW; i++)
            send_event(make_event(MODE_INIT, (window_x + i % WINDOW) % SIDE,
                                  (window_y + i / WINDOW) % SIDE,
                                  DIR_W'($urandom), {$urandom, $urandom}));
        for (int i = 0; i < count; i++)
            send_event(random_event($urandom_range(0, 99) < 15));
    endtask

    task automatic apply_reset();
        for (int i = 0; i < CELLS; i++)
            lattice_cells[i] = OCC_EMPTY;
        predator_cells = 0;
        prey_cells = 0;
        thresholds.death_threshold = DEATH_RESET;
        thresholds.eat_threshold = EAT_RESET;
        thresholds.birth_threshold = BIRTH_RESET;
        thresholds.init_predator_bound = INIT_PRED_RESET;
        thresholds.init_prey_bound = INIT_PREY_RESET;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    endtask

    // Hand-picked events under the reset thresholds: draws at and next to each
    // threshold, corner cells so every direction wraps, every mode including
    // the unused ones, and events that must leave the lattice alone. The first
    // transfer also waits out the clearing sweep.
    task automatic test_directed_events();
        send_event(make_event(MODE_IDLE, 5, 5, DIR_ROW_INC, '0));
        send_event(make_event(MODE_DIE, 0, 0, DIR_ROW_INC, '0));
        send_event(make_event(MODE_INIT, 0, 0, DIR_ROW_INC, '0));
        send_event(make_event(MODE_INIT, 0, SIDE - 1, DIR_ROW_INC, INIT_PRED_RESET));
        send_event(make_event(MODE_INIT, SIDE - 1, 0, DIR_ROW_INC, INIT_PREY_RESET - 1));
        send_event(make_event(MODE_INIT, SIDE - 1, SIDE - 1, DIR_ROW_INC, INIT_PREY_RESET));
        send_event(make_event(MODE_INIT, SIDE - 1, SIDE - 1, DIR_ROW_INC, INIT_PRED_RESET - 1));
        // Predation through the bottom edge, first just failing, then passing.
        send_event(make_event(MODE_EAT, 0, 0, DIR_ROW_DEC, EAT_RESET));
        send_event(make_event(MODE_EAT, 0, 0, DIR_ROW_DEC, EAT_RESET - 1));
        // Birth always passes at reset, even with an all-ones draw.
        send_event(make_event(MODE_BIRTH, SIDE - 1, 0, DIR_COL_INC, ALL_ONES));
        send_event(make_event(MODE_BIRTH, SIDE - 1, 0, DIR_COL_DEC, ALL_ONES));
        send_event(make_event(MODE_BIRTH, SIDE - 1, 0, DIR_ROW_DEC, ALL_ONES));
        send_event(make_event(MODE_EAT, SIDE - 1, SIDE - 1, DIR_ROW_INC, '0));
        send_event(make_event(MODE_DIE, 0, 0, DIR_ROW_INC, DEATH_RESET));
        send_event(make_event(MODE_DIE, 0, 0, DIR_ROW_INC, DEATH_RESET - 1));
        send_event(make_event(MODE_BIRTH, SIDE - 2, 0, DIR_ROW_INC, {$urandom, $urandom}));
        send_event(make_event(MODE_BIRTH, SIDE - 2, 1, DIR_COL_INC, '0));
        send_event(make_event(MODE_EAT, SIDE - 1, 0, DIR_COL_INC, '0));
        send_event(make_event(MODE_EAT, 0, SIDE - 1, DIR_COL_DEC, '0));
        send_event(make_event(MODE_EAT, SIDE - 2, 0, DIR_COL_INC, '0));
        send_event(make_event(MODE_EAT, SIDE - 1, 0, DIR_ROW_INC, ALL_ONES));
        send_event(make_event(MODE_EAT, SIDE - 1, 0, DIR_ROW_INC, '0));
        send_event(make_event(MODE_DIE, SIDE - 2, 0, DIR_ROW_INC, '0));
        for (int m = MODE_INIT + 1; m < 8; m++)
            send_event(make_event(MODE_W'(m), 0, SIDE - 1, DIR_ROW_INC, '0));
        drain_results();
    endtask

    // Registers at their extremes: always and never for each probability, and
    // initialization bounds that make one occupant impossible.
    task automatic test_threshold_extremes();
        write_all_registers(ALL_ONES, ALL_ONES, '0, HALF, ALL_ONES);
        run_event_burst(60);
        drain_results();
        write_all_registers('0, '0, ALL_ONES, '0, HALF);
        run_event_burst(60);
        drain_results();
        write_all_registers(HALF, HALF, HALF, ALL_ONES, '0);
        run_event_burst(60);
        drain_results();
    endtask

    // Random register settings, each followed by a burst of random events.
    // Some bursts run with one or both sides never idling.
    task automatic test_random_events();
        for (int phase = 0; phase < 5; phase++)
        begin
            write_all_registers(random_threshold(), random_threshold(), random_threshold(),
                                random_threshold(), random_threshold());
            sender_gaps_on = (phase != 1) && (phase != 3);
            receiver_gaps_on = (phase != 2) && (phase != 3);
            run_event_burst(180);
            drain_results();
        end
        sender_gaps_on = 1'b1;
        receiver_gaps_on = 1'b1;
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering back to back, so the engine fills and stalls its input.
    task automatic test_long_result_hold();
        write_all_registers(DEATH_RESET, EAT_RESET, BIRTH_RESET,
                            INIT_PRED_RESET, INIT_PREY_RESET);
        sender_gaps_on = 1'b0;
        receiver_hold_cycles = 400;
        run_event_burst(90);
        drain_results();
        sender_gaps_on = 1'b1;
    endtask

    // The sender stops mid-stream until every result is back, then resumes
    // on the same lattice contents.
    task automatic test_sender_pause();
        run_event_burst(40);
        drain_results();
        for (int i = 0; i < 40; i++)
            send_event(random_event(1'b0));
        drain_results();
    endtask

    // Result receiver: stall pattern plus the long hold-off counted here.
    initial
    begin : result_stall_driver
        int unsigned stall_left;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (receiver_hold_cycles > 0)
            begin
                result_stall <= 1'b1;
                receiver_hold_cycles--;
            end
            else if (stall_left > 0)
            begin
                result_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                result_stall <= 1'b0;
                if (receiver_gaps_on)
                    stall_left = pick_gap();
            end
        end
    end

    task automatic check_field(input string name, input logic [DRAW_W-1:0] want,
                               input logic [DRAW_W-1:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    // Every result transfer is compared with the oldest prediction.
    always @(posedge clk)
    begin : result_checker
        lpp_result_t expected;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transfer with no event outstanding");
                error_count++;
            end
            else
            begin
                expected = pending_results.pop_front();
                check_field("changed", expected.changed, result.changed);
                check_field("target_x", expected.target_x, result.target_x);
                check_field("target_y", expected.target_y, result.target_y);
                check_field("new_occupant", expected.new_occupant, result.new_occupant);
                check_field("predator_total", expected.predator_total, result.predator_total);
                check_field("prey_total", expected.prey_total, result.prey_total);
            end
        end
    end

    initial
    begin
        apply_reset();
        test_directed_events();
        test_threshold_extremes();
        test_random_events();
        test_long_result_hold();
        test_sender_pause();
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Guards against a hung handshake.
    initial
    begin
        #WATCHDOG_NS;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
